// ===== hdl/fcsg_pkg.sv =====
// Shared types, constants and tables for the four-channel sound generator.
package fcsg_pkg;

   localparam int FramePeriodDefault = 8192;
   localparam logic [7:0] TicksDefault = 8'd95;

   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [5:0] reg_addr;
      logic [7:0] write_data;
   } req_type_type;

   typedef struct packed {
      logic [15:0] left_pcm;
      logic [15:0] right_pcm;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic do_write;
      logic do_tick;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic        emit;
      logic [15:0] left_pcm;
      logic [15:0] right_pcm;
   } stat_type;

   function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
      logic [7:0] row;
      begin
         unique case (sel)
            2'd0: row = 8'b1000_0000;
            2'd1: row = 8'b1000_0001;
            2'd2: row = 8'b1110_0001;
            default: row = 8'b0111_1110;
         endcase
         // row bit 0 is step 0
         duty_bit = row[pos];
      end
   endfunction

   function automatic logic [21:0] noise_period(input logic [7:0] r);
      logic [6:0] base;
      begin
         unique case (r[2:0])
            3'd0: base = 7'd8;
            3'd1: base = 7'd16;
            3'd2: base = 7'd32;
            3'd3: base = 7'd48;
            3'd4: base = 7'd64;
            3'd5: base = 7'd80;
            3'd6: base = 7'd96;
            default: base = 7'd112;
         endcase
         noise_period = {15'd0, base} << r[7:4];
      end
   endfunction

endpackage

// ===== hdl/fcsg_datapath.sv =====
// Datapath: register file, wave memory, channel state, mixer and downsampler.
module fcsg_datapath #(
   parameter int FRAME_PERIOD = fcsg_pkg::FramePeriodDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fcsg_pkg::cmd_type      cmd,
   input  fcsg_pkg::req_type_type req,
   input  logic [7:0]             ticks_per_output,
   output fcsg_pkg::stat_type     stat
);
   localparam int FW = $clog2(FRAME_PERIOD + 1);

   logic [7:0]  regs_ff [32];
   logic [7:0]  regs_in [32];
   logic [7:0]  wave_ff [16];
   logic [7:0]  wave_in [16];
   logic [3:0]  on_ff, on_in;
   logic [21:0] tmr_ff [4];
   logic [21:0] tmr_in [4];
   logic [2:0]  duty_ff [2];
   logic [2:0]  duty_in [2];
   logic [4:0]  wpos_ff, wpos_in;
   logic [14:0] lfsr_ff, lfsr_in;
   logic [8:0]  len_ff [4];
   logic [8:0]  len_in [4];
   logic [3:0]  envv_ff [3];
   logic [3:0]  envv_in [3];
   logic [3:0]  envt_ff [3];
   logic [3:0]  envt_in [3];
   logic [3:0]  envs_ff [3];
   logic [3:0]  envs_in [3];
   logic [10:0] shf_ff, shf_in;
   logic [11:0] swp_ff, swp_in;
   logic [FW-1:0] fcnt_ff, fcnt_in;
   logic [2:0]  fstep_ff, fstep_in;
   logic [7:0]  scnt_ff, scnt_in;
   logic        emit_ff, emit_in;
   logic [6:0]  lprod_ff, lprod_in, rprod_ff, rprod_in;
   logic [15:0] lpcm_ff, rpcm_ff;

   function automatic logic [21:0] pulse_per(input logic [7:0] lo, input logic [7:0] hi,
                                             input logic one_x);
      logic [11:0] d;
      begin
         d = 12'd2048 - {1'b0, hi[2:0], lo};
         pulse_per = one_x ? {9'd0, d, 1'b0} : {8'd0, d, 2'b00};
      end
   endfunction

   // power-on value of each sound register
   function automatic logic [7:0] reg_default(input logic [4:0] idx);
      logic [7:0] v;
      begin
         unique case (idx)
            5'd0:  v = 8'h80;
            5'd1:  v = 8'hBF;
            5'd2:  v = 8'hF3;
            5'd4:  v = 8'hBF;
            5'd6:  v = 8'h3F;
            5'd9:  v = 8'hBF;
            5'd10: v = 8'h7F;
            5'd11: v = 8'hFF;
            5'd12: v = 8'h9F;
            5'd14: v = 8'hBF;
            5'd16: v = 8'hFF;
            5'd19: v = 8'hBF;
            5'd20: v = 8'h77;
            5'd21: v = 8'hF3;
            5'd22: v = 8'hF1;
            default: v = 8'h00;
         endcase
         reg_default = v;
      end
   endfunction

   always_comb begin
      logic [7:0]  old;
      logic [7:0]  d;
      logic [5:0]  a;
      logic [2:0]  per, sh;
      logic [3:0]  t;
      logic [11:0] nf;
      logic [10:0] dd;
      logic        lc, sc, ec;
      logic [3:0]  s [4];
      logic [6:0]  l, r;
      logic [7:0]  b;
      logic        x;
      logic [14:0] lf;
      logic [7:0]  sc_next;
      for (int i = 0; i < 32; i++) regs_in[i] = regs_ff[i];
      for (int i = 0; i < 16; i++) wave_in[i] = wave_ff[i];
      on_in = on_ff;
      for (int i = 0; i < 4; i++) begin tmr_in[i] = tmr_ff[i]; len_in[i] = len_ff[i]; end
      for (int i = 0; i < 2; i++) duty_in[i] = duty_ff[i];
      for (int i = 0; i < 3; i++) begin
         envv_in[i] = envv_ff[i]; envt_in[i] = envt_ff[i]; envs_in[i] = envs_ff[i];
      end
      wpos_in = wpos_ff; lfsr_in = lfsr_ff; shf_in = shf_ff; swp_in = swp_ff;
      fcnt_in = fcnt_ff; fstep_in = fstep_ff; scnt_in = scnt_ff;
      emit_in = 1'b0; lprod_in = lprod_ff; rprod_in = rprod_ff;
      old = '0; d = req.write_data; a = req.reg_addr;
      per = '0; sh = '0; t = '0; nf = '0; dd = '0; lc = 1'b0; sc = 1'b0; ec = 1'b0;
      for (int i = 0; i < 4; i++) s[i] = '0;
      l = '0; r = '0; b = '0; x = 1'b0; lf = '0; sc_next = '0;

      if (cmd.do_write) begin
         if (a[5]) begin
            if (a[4] == 1'b0) wave_in[a[3:0]] = d;
         end else begin
            old = regs_ff[a[4:0]];
            regs_in[a[4:0]] = d;
            if (old != d && d[7]) begin
               if (a == 6'h04) begin
                  on_in[0] = 1'b1;
                  if (len_ff[0] == '0) len_in[0] = 9'd64;
                  tmr_in[0] = pulse_per(regs_ff[3], d, 1'b0);
                  envv_in[0] = regs_ff[2][7:4]; envs_in[0] = regs_ff[2][3:0];
                  envt_in[0] = {1'b0, regs_ff[2][2:0]};
                  shf_in = {d[2:0], regs_ff[3]};
                  per = regs_ff[0][6:4]; sh = regs_ff[0][2:0];
                  swp_in = {(per != 0) ? {1'b0, per} : 4'd8,
                            ((per != 0) || (sh != 0)), per, regs_ff[0][3], sh};
               end else if (a == 6'h09) begin
                  on_in[1] = 1'b1;
                  if (len_ff[1] == '0) len_in[1] = 9'd64;
                  tmr_in[1] = pulse_per(regs_ff[8], d, 1'b0);
                  envv_in[1] = regs_ff[7][7:4]; envs_in[1] = regs_ff[7][3:0];
                  envt_in[1] = {1'b0, regs_ff[7][2:0]};
               end else if (a == 6'h0E) begin
                  on_in[2] = 1'b1;
                  if (len_ff[2] == '0) len_in[2] = 9'd256;
                  tmr_in[2] = pulse_per(regs_ff[13], d, 1'b1);
                  wpos_in = '0;
               end else if (a == 6'h13) begin
                  on_in[3] = 1'b1;
                  if (len_ff[3] == '0) len_in[3] = 9'd64;
                  tmr_in[3] = fcsg_pkg::noise_period(regs_ff[18]);
                  envv_in[2] = regs_ff[17][7:4]; envs_in[2] = regs_ff[17][3:0];
                  envt_in[2] = {1'b0, regs_ff[17][2:0]};
                  lfsr_in = 15'h7FFF;
               end
            end
         end
      end else if (cmd.do_tick) begin
         if (!regs_ff[22][7]) begin
            regs_in[20] = 8'h77; regs_in[21] = 8'hF3; regs_in[22] = 8'hF1;
            regs_in[0] = 8'h80; regs_in[1] = 8'hBF; regs_in[2] = 8'hF3;
            regs_in[4] = 8'hBF; regs_in[6] = 8'h3F; regs_in[7] = 8'h00;
            regs_in[9] = 8'hBF; regs_in[10] = 8'h7F; regs_in[11] = 8'hFF;
            regs_in[12] = 8'h9F; regs_in[14] = 8'hBF; regs_in[16] = 8'hFF;
            regs_in[17] = 8'h00; regs_in[18] = 8'h00; regs_in[19] = 8'hBF;
            for (int i = 0; i < 16; i++) wave_in[i] = '0;
            on_in = '0;
            for (int i = 0; i < 4; i++) tmr_in[i] = '0;
            duty_in[0] = '0; duty_in[1] = '0; wpos_in = '0; lfsr_in = 15'h7FFF;
            fcnt_in = FW'(FRAME_PERIOD); fstep_in = '0; scnt_in = '0;
         end else begin
            if (fcnt_ff == '0) begin
               fcnt_in = FW'(FRAME_PERIOD);
               lc = (fstep_ff[0] == 1'b0);
               sc = (fstep_ff == 3'd2) || (fstep_ff == 3'd6);
               ec = (fstep_ff == 3'd7);
               fstep_in = fstep_ff + 3'd1;
            end else begin
               fcnt_in = fcnt_ff - FW'(1);
            end
            // sweep runs before length
            if (sc && swp_ff[7] && swp_ff[6:4] != 0) begin
               t = swp_ff[11:8];
               if (t > 4'd1) t = t - 4'd1;
               else begin
                  dd = shf_ff >> swp_ff[2:0];
                  nf = swp_ff[3] ? ({1'b0, shf_ff} - {1'b0, dd})
                                 : ({1'b0, shf_ff} + {1'b0, dd});
                  t = {1'b0, swp_ff[6:4]};
                  if (nf <= 12'd2047 && swp_ff[2:0] != 0) begin
                     shf_in = nf[10:0];
                     regs_in[3] = nf[7:0];
                     regs_in[4] = {regs_ff[4][7:3], nf[10:8]};
                  end else if (nf > 12'd2047) begin
                     on_in[0] = 1'b0;
                  end
               end
               swp_in = {t, swp_ff[7:0]};
            end
            if (lc) begin
               for (int i = 0; i < 4; i++) begin
                  if (regs_ff[4 + 5*i][6] && len_ff[i] != 0) begin
                     len_in[i] = len_ff[i] - 9'd1;
                     if (len_ff[i] == 9'd1) on_in[i] = 1'b0;
                  end
               end
            end
            if (ec) begin
               for (int e = 0; e < 3; e++) begin
                  if (envs_ff[e][2:0] != 0) begin
                     if (envt_ff[e] > 4'd1) envt_in[e] = envt_ff[e] - 4'd1;
                     else begin
                        envt_in[e] = {1'b0, envs_ff[e][2:0]};
                        if (envs_ff[e][3] && envv_ff[e] < 4'd15)
                           envv_in[e] = envv_ff[e] + 4'd1;
                        else if (!envs_ff[e][3] && envv_ff[e] > 4'd0)
                           envv_in[e] = envv_ff[e] - 4'd1;
                     end
                  end
               end
            end
            // channels use the on state as it stands after frame events
            for (int c = 0; c < 2; c++) begin
               if (on_in[c]) begin
                  if (tmr_ff[c] <= 22'd1) begin
                     tmr_in[c] = pulse_per(regs_in[3 + 5*c], regs_in[4 + 5*c], 1'b0);
                     duty_in[c] = duty_ff[c] + 3'd1;
                  end else tmr_in[c] = tmr_ff[c] - 22'd1;
                  s[c] = fcsg_pkg::duty_bit(regs_ff[1 + 5*c][7:6], duty_in[c])
                         ? envv_in[c] : 4'd0;
               end
            end
            if (on_in[2] && regs_ff[10][7]) begin
               if (tmr_ff[2] <= 22'd1) begin
                  tmr_in[2] = pulse_per(regs_ff[13], regs_ff[14], 1'b1);
                  wpos_in = wpos_ff + 5'd1;
               end else tmr_in[2] = tmr_ff[2] - 22'd1;
               b = wave_ff[wpos_in[4:1]];
               s[2] = wpos_in[0] ? b[3:0] : b[7:4];
               unique case (regs_ff[12][6:5])
                  2'd0: s[2] = 4'd0;
                  2'd1: s[2] = s[2];
                  2'd2: s[2] = s[2] >> 1;
                  default: s[2] = s[2] >> 2;
               endcase
            end
            if (on_in[3]) begin
               lf = lfsr_ff;
               if (tmr_ff[3] <= 22'd1) begin
                  x = lf[0] ^ lf[1];
                  tmr_in[3] = fcsg_pkg::noise_period(regs_ff[18]);
                  lf = {x, lf[14:1]};
                  if (regs_ff[18][3]) lf[6] = x;
                  lfsr_in = lf;
               end else tmr_in[3] = tmr_ff[3] - 22'd1;
               s[3] = lf[0] ? 4'd0 : envv_in[2];
            end
            for (int i = 0; i < 4; i++) begin
               if (regs_ff[21][4+i]) l = l + {3'd0, s[i]};
               if (regs_ff[21][i])   r = r + {3'd0, s[i]};
            end
            sc_next = scnt_ff + 8'd1;
            if (sc_next >= ticks_per_output) begin
               scnt_in = '0;
               emit_in = 1'b1;
               lprod_in = l;
               rprod_in = r;
            end else scnt_in = sc_next;
         end
      end
   end

   // master volume sampled at emit time; product formed next cycle
   logic [2:0] lmv_ff, rmv_ff;
   logic       emit2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) regs_ff[i] <= reg_default(5'(i));
         for (int i = 0; i < 16; i++) wave_ff[i] <= '0;
         for (int i = 0; i < 4; i++) begin tmr_ff[i] <= '0; len_ff[i] <= '0; end
         for (int i = 0; i < 2; i++) duty_ff[i] <= '0;
         for (int i = 0; i < 3; i++) begin
            envv_ff[i] <= '0; envt_ff[i] <= '0; envs_ff[i] <= '0;
         end
         wpos_ff <= '0; lfsr_ff <= 15'h7FFF; shf_ff <= '0; swp_ff <= '0;
         fcnt_ff <= FW'(FRAME_PERIOD); fstep_ff <= '0; scnt_ff <= '0; on_ff <= '0;
         emit_ff <= 1'b0; emit2_ff <= 1'b0;
      end else begin
         for (int i = 0; i < 32; i++) regs_ff[i] <= regs_in[i];
         for (int i = 0; i < 16; i++) wave_ff[i] <= wave_in[i];
         for (int i = 0; i < 4; i++) begin tmr_ff[i] <= tmr_in[i]; len_ff[i] <= len_in[i]; end
         for (int i = 0; i < 2; i++) duty_ff[i] <= duty_in[i];
         for (int i = 0; i < 3; i++) begin
            envv_ff[i] <= envv_in[i]; envt_ff[i] <= envt_in[i]; envs_ff[i] <= envs_in[i];
         end
         wpos_ff <= wpos_in; lfsr_ff <= lfsr_in; shf_ff <= shf_in; swp_ff <= swp_in;
         fcnt_ff <= fcnt_in; fstep_ff <= fstep_in; scnt_ff <= scnt_in; on_ff <= on_in;
         emit_ff <= emit_in;
         emit2_ff <= emit_ff;
      end
      lprod_ff <= lprod_in; rprod_ff <= rprod_in;
      if (emit_in) begin
         lmv_ff <= regs_ff[20][2:0];
         rmv_ff <= regs_ff[20][6:4];
      end
      if (emit_ff) begin
         lpcm_ff <= {9'd0, lprod_ff} * {13'd0, lmv_ff} * 16'd120;
         rpcm_ff <= {9'd0, rprod_ff} * {13'd0, rmv_ff} * 16'd120;
      end
   end

   assign stat.emit      = emit2_ff;
   assign stat.left_pcm  = lpcm_ff;
   assign stat.right_pcm = rpcm_ff;

endmodule

// ===== hdl/fcsg_ctrl.sv =====
// Controller: request handshake, command issue and result holding register.
module fcsg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fcsg_pkg::req_type_type req_in,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fcsg_pkg::rsp_type      rsp_out,
   output fcsg_pkg::cmd_type      cmd,
   input  fcsg_pkg::stat_type     stat
);
   typedef enum logic [1:0] {ST_IDLE, ST_WAIT1, ST_WAIT2} state_type;

   state_type         state_ff, state_in;
   logic              full_ff, full_in;
   logic              spare_ff, spare_in;
   fcsg_pkg::rsp_type data_ff, data_in;
   fcsg_pkg::rsp_type hold_ff, hold_in;
   logic              take;

   // a tick emits in ST_WAIT2; the spare slot catches it if the output still waits
   assign req_ready = (state_ff == ST_IDLE) && !spare_ff;
   assign take      = req_valid && req_ready;
   assign cmd.do_write = take && (req_in.req_type == fcsg_pkg::REQ_WRITE);
   assign cmd.do_tick  = take && (req_in.req_type == fcsg_pkg::REQ_TICK);

   always_comb begin
      state_in = state_ff;
      full_in  = full_ff;
      spare_in = spare_ff;
      data_in  = data_ff;
      hold_in  = hold_ff;
      if (rsp_valid && rsp_ready) full_in = 1'b0;
      // older pair moves up as soon as the output slot frees
      if (!full_in && spare_ff) begin
         full_in  = 1'b1;
         data_in  = hold_ff;
         spare_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE:  if (cmd.do_tick) state_in = ST_WAIT1;
         ST_WAIT1: state_in = ST_WAIT2;
         default: begin
            state_in = ST_IDLE;
            if (stat.emit) begin
               if (!full_in) begin
                  full_in = 1'b1;
                  data_in.left_pcm  = stat.left_pcm;
                  data_in.right_pcm = stat.right_pcm;
               end else begin
                  spare_in = 1'b1;
                  hold_in.left_pcm  = stat.left_pcm;
                  hold_in.right_pcm = stat.right_pcm;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         full_ff  <= 1'b0;
         spare_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         full_ff  <= full_in;
         spare_ff <= spare_in;
      end
      data_ff <= data_in;
      hold_ff <= hold_in;
   end

   assign rsp_valid = full_ff;
   assign rsp_out   = data_ff;

endmodule

// ===== hdl/four_channel_sound_generator_unit.sv =====
// Top level of the four-channel sound generator.
// Usage:
//  The req channel carries one beat per register write or per sound clock
//  tick (req_type 0 = tick, 1 = write; reg_addr 32..47 addresses wave memory).
//  The rsp channel carries a left/right PCM pair every ticks_per_output ticks.
//  csr_write_enable/csr_write_data set ticks_per_output (reset value 95);
//  write it only while the block is idle.
// Tick path:
//  A write beat is taken while the controller stays idle. A tick beat first
//  updates the channels and registers the mix, then forms the master volume
//  product, then loads the output register, which raises rsp_valid. No new
//  beat is taken until the controller is back from ST_WAIT1 and ST_WAIT2.
// Reset:
//  Synchronous reset loads the power-on register defaults, clears wave
//  memory and channel state, sets the LFSR to all ones and drops rsp_valid.
// Stall:
//  A result waits in the output register while rsp_ready is low; one more
//  pair fits in a spare register, and req_ready stays low while that is
//  occupied, so no pair is ever lost.
module four_channel_sound_generator_unit #(
   parameter int FRAME_PERIOD = fcsg_pkg::FramePeriodDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fcsg_pkg::req_type_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fcsg_pkg::rsp_type      rsp_data,
   input  logic                   csr_write_enable,
   input  logic [7:0]             csr_write_data
);
   logic [7:0]         tpo_ff;
   fcsg_pkg::cmd_type  cmd;
   fcsg_pkg::stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) tpo_ff <= fcsg_pkg::TicksDefault;
      else if (csr_write_enable) tpo_ff <= csr_write_data;
   end

   fcsg_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_in(req_data),
      .rsp_valid, .rsp_ready, .rsp_out(rsp_data), .cmd, .stat
   );

   fcsg_datapath #(.FRAME_PERIOD(FRAME_PERIOD)) u_dp (
      .clock, .reset, .cmd, .req(req_data), .ticks_per_output(tpo_ff), .stat
   );

endmodule

// ===== hdl/fcsg_checker.sv =====
// Port-level checker for the sound generator, bound to the top level.
module fcsg_port_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input fcsg_pkg::req_type_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input fcsg_pkg::rsp_type      rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");
   a_known_handshake: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_ready, rsp_valid}))
      else $error("handshake output unknown");
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.req_type && !rsp_valid |=> !rsp_valid)
      else $error("write produced a result");
   a_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");
endmodule

bind four_channel_sound_generator_unit fcsg_port_checker u_fcsg_checker (
   .clock, .reset, .req_valid, .req_ready, .req_data,
   .rsp_valid, .rsp_ready, .rsp_data
);

// ===== test/fcsg_checker.sv =====
// Sound generator scoreboard: register map constants, beat predictor and PCM pair checker.
package fcsg_tb_pkg;
   localparam logic [5:0] NR10 = 6'h00;
   localparam logic [5:0] NR11 = 6'h01;
   localparam logic [5:0] NR12 = 6'h02;
   localparam logic [5:0] NR13 = 6'h03;
   localparam logic [5:0] NR14 = 6'h04;
   localparam logic [5:0] NR21 = 6'h06;
   localparam logic [5:0] NR22 = 6'h07;
   localparam logic [5:0] NR23 = 6'h08;
   localparam logic [5:0] NR24 = 6'h09;
   localparam logic [5:0] NR30 = 6'h0A;
   localparam logic [5:0] NR31 = 6'h0B;
   localparam logic [5:0] NR32 = 6'h0C;
   localparam logic [5:0] NR33 = 6'h0D;
   localparam logic [5:0] NR34 = 6'h0E;
   localparam logic [5:0] NR41 = 6'h10;
   localparam logic [5:0] NR42 = 6'h11;
   localparam logic [5:0] NR43 = 6'h12;
   localparam logic [5:0] NR44 = 6'h13;
   localparam logic [5:0] NR50 = 6'h14;
   localparam logic [5:0] NR51 = 6'h15;
   localparam logic [5:0] NR52 = 6'h16;
   localparam logic [5:0] WAVE_FIRST = 6'd32;
   localparam logic [5:0] WAVE_LAST = 6'd47;
endpackage

module fcsg_checker #(
   parameter int FRAME_PERIOD = 8192
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  fcsg_pkg::req_type_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  fcsg_pkg::rsp_type      rsp_data,
   input  logic                   csr_write_enable,
   input  logic [7:0]             csr_write_data,
   output int                     fail_count,
   output int                     pending,
   output int                     pairs_checked,
   output int                     ticks_seen
);
   import fcsg_pkg::*;
   import fcsg_tb_pkg::*;

   localparam logic [7:0] DUTY_ROWS [4] = '{8'b1000_0000, 8'b1000_0001,
                                            8'b1110_0001, 8'b0111_1110};
   localparam int NOISE_BASE [8] = '{8, 16, 32, 48, 64, 80, 96, 112};

   logic [7:0]  regs_q [32];
   logic [7:0]  wave_q [16];
   logic        on_q [4];
   logic [21:0] tmr_q [4];
   logic [2:0]  duty_q [2];
   logic [4:0]  wpos_q;
   logic [14:0] lfsr_q;
   logic [8:0]  len_q [4];
   logic [3:0]  vol_q [3];
   logic [3:0]  etmr_q [3];
   logic [3:0]  eset_q [3];
   logic [10:0] shadow_q;
   logic [11:0] sweep_q;
   logic [13:0] frame_cnt_q;
   logic [2:0]  frame_step_q;
   logic [7:0]  smp_cnt_q;
   logic [7:0]  tpo_q;

   rsp_type pcm_expected [$];

   function automatic void power_defaults();
      regs_q[NR50] = 8'h77; regs_q[NR51] = 8'hF3; regs_q[NR52] = 8'hF1;
      regs_q[NR10] = 8'h80; regs_q[NR11] = 8'hBF; regs_q[NR12] = 8'hF3;
      regs_q[NR14] = 8'hBF; regs_q[NR21] = 8'h3F; regs_q[NR22] = 8'h00;
      regs_q[NR24] = 8'hBF; regs_q[NR30] = 8'h7F; regs_q[NR31] = 8'hFF;
      regs_q[NR32] = 8'h9F; regs_q[NR34] = 8'hBF; regs_q[NR41] = 8'hFF;
      regs_q[NR42] = 8'h00; regs_q[NR43] = 8'h00; regs_q[NR44] = 8'hBF;
      for (int i = 0; i < 16; i++) wave_q[i] = 8'h00;
      for (int i = 0; i < 4; i++) begin
         on_q[i] = 1'b0;
         tmr_q[i] = '0;
      end
      duty_q[0] = '0; duty_q[1] = '0;
      wpos_q = '0;
      lfsr_q = 15'h7FFF;
      frame_cnt_q = 14'(FRAME_PERIOD);
      frame_step_q = '0;
      smp_cnt_q = '0;
   endfunction

   function automatic void model_reset();
      for (int i = 0; i < 32; i++) regs_q[i] = 8'h00;
      for (int i = 0; i < 4; i++) len_q[i] = '0;
      for (int e = 0; e < 3; e++) begin
         vol_q[e] = '0; etmr_q[e] = '0; eset_q[e] = '0;
      end
      shadow_q = '0;
      sweep_q = '0;
      tpo_q = TicksDefault;
      power_defaults();
   endfunction

   function automatic int freq_of(logic [5:0] lo, logic [5:0] hi);
      return {regs_q[hi][2:0], regs_q[lo]};
   endfunction

   function automatic int noise_per();
      return NOISE_BASE[regs_q[NR43][2:0]] << regs_q[NR43][7:4];
   endfunction

   function automatic void env_load(int e, logic [7:0] r);
      vol_q[e] = r[7:4];
      eset_q[e] = r[3:0];
      etmr_q[e] = {1'b0, r[2:0]};
   endfunction

   function automatic void start_channel(int ch);
      logic [2:0] per, shift;
      int f;
      on_q[ch] = 1'b1;
      if (len_q[ch] == 0) len_q[ch] = (ch == 2) ? 9'd256 : 9'd64;
      case (ch)
         0: begin
            f = freq_of(NR13, NR14);
            per = regs_q[NR10][6:4];
            shift = regs_q[NR10][2:0];
            tmr_q[0] = 22'((2048 - f) * 4);
            env_load(0, regs_q[NR12]);
            shadow_q = 11'(f);
            sweep_q = {(per != 0) ? {1'b0, per} : 4'd8,
                       (per != 0 || shift != 0), per, regs_q[NR10][3], shift};
         end
         1: begin
            tmr_q[1] = 22'((2048 - freq_of(NR23, NR24)) * 4);
            env_load(1, regs_q[NR22]);
         end
         2: begin
            tmr_q[2] = 22'((2048 - freq_of(NR33, NR34)) * 2);
            wpos_q = '0;
         end
         default: begin
            tmr_q[3] = 22'(noise_per());
            env_load(2, regs_q[NR42]);
            lfsr_q = 15'h7FFF;
         end
      endcase
   endfunction

   function automatic void length_clock();
      logic [5:0] ctl [4];
      ctl = '{NR14, NR24, NR34, NR44};
      for (int i = 0; i < 4; i++)
         if (regs_q[ctl[i]][6] && len_q[i] > 0) begin
            len_q[i]--;
            if (len_q[i] == 0) on_q[i] = 1'b0;
         end
   endfunction

   function automatic void sweep_clock();
      logic [2:0] per, shift;
      logic [3:0] tmr;
      int d, nf;
      per = sweep_q[6:4];
      tmr = sweep_q[11:8];
      shift = sweep_q[2:0];
      if (!sweep_q[7] || per == 0) return;
      if (tmr > 1) begin
         tmr--;
      end else begin
         d = shadow_q >> shift;
         nf = sweep_q[3] ? shadow_q - d : shadow_q + d;
         tmr = {1'b0, per};
         if (nf <= 2047 && shift > 0) begin
            shadow_q = 11'(nf);
            regs_q[NR13] = nf[7:0];
            regs_q[NR14] = {regs_q[NR14][7:3], nf[10:8]};
         end else if (nf > 2047) begin
            on_q[0] = 1'b0;
         end
      end
      sweep_q[11:8] = tmr;
   endfunction

   function automatic void env_clock();
      for (int e = 0; e < 3; e++) begin
         if (eset_q[e][2:0] == 0) continue;
         if (etmr_q[e] > 1) begin
            etmr_q[e]--;
            continue;
         end
         etmr_q[e] = {1'b0, eset_q[e][2:0]};
         if (eset_q[e][3] && vol_q[e] < 15) vol_q[e]++;
         else if (!eset_q[e][3] && vol_q[e] > 0) vol_q[e]--;
      end
   endfunction

   // true when the channel's period runs out; otherwise counts the timer down
   function automatic bit period_done(int ch);
      if (tmr_q[ch] <= 1) return 1'b1;
      tmr_q[ch]--;
      return 1'b0;
   endfunction

   function automatic int pulse_level(int ch, logic [5:0] lo, logic [5:0] hi, logic [5:0] dreg);
      if (!on_q[ch]) return 0;
      if (period_done(ch)) begin
         tmr_q[ch] = 22'((2048 - freq_of(lo, hi)) * 4);
         duty_q[ch]++;
      end
      return DUTY_ROWS[regs_q[dreg][7:6]][duty_q[ch]] ? vol_q[ch] : 0;
   endfunction

   function automatic int wave_level();
      logic [7:0] b;
      logic [3:0] s;
      if (!on_q[2] || !regs_q[NR30][7]) return 0;
      if (period_done(2)) begin
         tmr_q[2] = 22'((2048 - freq_of(NR33, NR34)) * 2);
         wpos_q++;
      end
      b = wave_q[wpos_q[4:1]];
      s = wpos_q[0] ? b[3:0] : b[7:4];
      case (regs_q[NR32][6:5])
         2'd0: return 0;
         2'd1: return s;
         2'd2: return s >> 1;
         default: return s >> 2;
      endcase
   endfunction

   function automatic int noise_level();
      logic [14:0] l;
      logic x;
      if (!on_q[3]) return 0;
      if (period_done(3)) begin
         l = lfsr_q;
         x = l[0] ^ l[1];
         tmr_q[3] = 22'(noise_per());
         l = {x, l[14:1]};
         if (regs_q[NR43][3]) l[6] = x;
         lfsr_q = l;
      end
      return lfsr_q[0] ? 0 : vol_q[2];
   endfunction

   // applies one beat, returns 1 with the pair when the downsampler fires
   function automatic bit apply_beat(req_type_type rq, output rsp_type pair);
      logic [7:0] old, mv;
      int lvl [4];
      int left, right;
      pair = '0;
      if (rq.req_type == REQ_WRITE) begin
         if (rq.reg_addr >= WAVE_FIRST && rq.reg_addr <= WAVE_LAST) begin
            wave_q[rq.reg_addr - WAVE_FIRST] = rq.write_data;
         end else if (rq.reg_addr < WAVE_FIRST) begin
            old = regs_q[rq.reg_addr];
            regs_q[rq.reg_addr] = rq.write_data;
            if (old != rq.write_data && rq.write_data[7]) begin
               case (rq.reg_addr)
                  NR14: start_channel(0);
                  NR24: start_channel(1);
                  NR34: start_channel(2);
                  NR44: start_channel(3);
                  default: ;
               endcase
            end
         end
         return 1'b0;
      end
      ticks_seen++;
      if (!regs_q[NR52][7]) begin
         power_defaults();
         return 1'b0;
      end
      if (frame_cnt_q == 0) begin
         frame_cnt_q = 14'(FRAME_PERIOD);
         case (frame_step_q)
            3'd0, 3'd4: length_clock();
            3'd2, 3'd6: begin
               sweep_clock();
               length_clock();
            end
            3'd7: env_clock();
            default: ;
         endcase
         frame_step_q++;
      end else begin
         frame_cnt_q--;
      end
      lvl[0] = pulse_level(0, NR13, NR14, NR11);
      lvl[1] = pulse_level(1, NR23, NR24, NR21);
      lvl[2] = wave_level();
      lvl[3] = noise_level();
      left = 0;
      right = 0;
      for (int i = 0; i < 4; i++) begin
         if (regs_q[NR51][4 + i]) left += lvl[i];
         if (regs_q[NR51][i]) right += lvl[i];
      end
      smp_cnt_q++;
      if (smp_cnt_q >= tpo_q) begin
         mv = regs_q[NR50];
         smp_cnt_q = '0;
         pair.left_pcm = 16'(left * mv[2:0] * 120);
         pair.right_pcm = 16'(right * mv[6:4] * 120);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      rsp_type pair, want;
      if (reset) begin
         model_reset();
         pcm_expected.delete();
      end else begin
         if (csr_write_enable) tpo_q = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (pcm_expected.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected pcm beat: left %0d right %0d",
                           rsp_data.left_pcm, rsp_data.right_pcm);
            end else begin
               want = pcm_expected.pop_front();
               pairs_checked++;
               if (rsp_data.left_pcm !== want.left_pcm
                   || rsp_data.right_pcm !== want.right_pcm) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("pcm pair %0d: expected left %0d right %0d, got left %0d right %0d",
                              pairs_checked, want.left_pcm, want.right_pcm,
                              rsp_data.left_pcm, rsp_data.right_pcm);
               end
            end
         end
         if (req_valid && req_ready && apply_beat(req_data, pair))
            pcm_expected.push_back(pair);
      end
      pending = pcm_expected.size();
   end

endmodule

// ===== test/four_channel_sound_generator_unit_tb.sv =====
// Stimulus and verdict for the four-channel sound generator unit.
module four_channel_sound_generator_unit_tb;
   import fcsg_pkg::*;
   import fcsg_tb_pkg::*;

   localparam int FRAME_LEN = 13;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BEATS = 225;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_type_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_type      rsp_data;
   logic         csr_write_enable = 1'b0;
   logic [7:0]   csr_write_data = '0;

   int fail_count, pending, pairs_checked, ticks_seen;
   int cycles = 0;
   int beats_sent = 0;
   int pairs_taken = 0;
   bit tx_burst = 1'b0;
   bit rx_burst = 1'b0;
   bit held_off = 1'b0;

   four_channel_sound_generator_unit #(.FRAME_PERIOD(FRAME_LEN)) dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_write_enable, .csr_write_data
   );

   fcsg_checker #(.FRAME_PERIOD(FRAME_LEN)) scoreboard (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_write_enable, .csr_write_data,
      .fail_count, .pending, .pairs_checked, .ticks_seen
   );

   always #4 clock = ~clock;

   always @(posedge clock) cycles <= cycles + 1;

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("four_channel_sound_generator_unit: mismatch");
      $finish;
   end

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_beat(req_type_type rq);
      int gap;
      if (!tx_burst && $urandom_range(0, 39) == 0) tx_burst = 1'b1;
      else if (tx_burst && $urandom_range(0, 29) == 0) tx_burst = 1'b0;
      gap = tx_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_write(logic [5:0] addr, logic [7:0] data);
      send_beat('{req_type: REQ_WRITE, reg_addr: addr, write_data: data});
   endtask

   task automatic send_ticks(int n);
      repeat (n) send_beat('{req_type: REQ_TICK, reg_addr: 6'($urandom),
                             write_data: 8'($urandom)});
   endtask

   // drain, let the pipeline settle, then change the output rate
   task automatic set_rate(logic [7:0] v);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic req_type_type rand_beat();
      req_type_type rq;
      int sel;
      rq = '{req_type: REQ_WRITE, reg_addr: 6'($urandom), write_data: 8'($urandom)};
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
         rq.req_type = REQ_TICK;
      end else if (sel < 68) begin
         case ($urandom_range(0, 3))
            0: rq.reg_addr = NR14;
            1: rq.reg_addr = NR24;
            2: rq.reg_addr = NR34;
            default: rq.reg_addr = NR44;
         endcase
         rq.write_data[7] = 1'b1;
         if ($urandom_range(0, 3) != 0) rq.write_data[2:0] = 3'd7;
      end else if (sel < 76) begin
         case ($urandom_range(0, 2))
            0: rq.reg_addr = NR13;
            1: rq.reg_addr = NR23;
            default: rq.reg_addr = NR33;
         endcase
         rq.write_data = 8'($urandom_range(192, 255));
      end else if (sel < 80) begin
         rq.reg_addr = NR43;
         rq.write_data[7:4] = 4'($urandom_range(0, 3));
      end else if (sel < 92) begin
         rq.reg_addr = 6'($urandom_range(0, 23));
      end else if (sel < 97) begin
         rq.reg_addr = 6'($urandom_range(WAVE_FIRST, WAVE_LAST));
      end
      return rq;
   endfunction

   // receiver; one long hold-off lets the block back up into its input
   initial begin
      int stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (!rx_burst && $urandom_range(0, 19) == 0) rx_burst = 1'b1;
         else if (rx_burst && $urandom_range(0, 14) == 0) rx_burst = 1'b0;
         stall = rx_burst ? 0 : $urandom_range(0, 14);
         if (pairs_taken == 30 && !held_off) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         pairs_taken++;
         @(negedge clock);
      end
   end

   initial begin
      logic [7:0] rates [5];
      rates = '{8'd0, 8'd255, 8'd3, 8'd7, 8'd1};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every channel started, wave memory ends, unused offset, power off
      send_ticks(2);
      set_rate(8'd1);
      send_write(WAVE_FIRST, 8'hF0);
      send_write(WAVE_LAST, 8'h0F);
      send_write(NR10, 8'h71);
      send_write(NR11, 8'hC0);
      send_write(NR12, 8'hF3);
      send_write(NR13, 8'hFF);
      send_write(NR14, 8'h87);
      send_write(NR22, 8'hA8);
      send_write(NR23, 8'hF0);
      send_write(NR24, 8'hC7);
      send_write(NR30, 8'h80);
      send_write(NR32, 8'h20);
      send_write(NR33, 8'hFE);
      send_write(NR34, 8'h87);
      send_write(NR42, 8'hF1);
      send_write(NR43, 8'h08);
      send_write(NR44, 8'hC0);
      send_write(NR51, 8'hFF);
      send_write(6'd63, 8'hFF);
      send_ticks(3);
      send_write(NR52, 8'h00);
      send_ticks(2);

      foreach (rates[p]) begin
         set_rate(rates[p]);
         repeat (PHASE_BEATS) send_beat(rand_beat());
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      $display("%0d beats sent, %0d ticks, %0d pcm pairs checked", beats_sent, ticks_seen,
               pairs_checked);
      $display("output rates 95, 1, 0, 255, 3, 7 with one long output stall and power-off cycles");
      if (fail_count == 0)
         $display("four_channel_sound_generator_unit: match");
      else
         $display("four_channel_sound_generator_unit: mismatch");
      $finish;
   end

endmodule
